FILE: design/eapt_pkg.sv
// eapt_pkg: shared types and constants for the encoder and press tracker
// payload structs, step control struct, reset values; no dependencies
`default_nettype none

package eapt_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned THRESH_W = 16;
    localparam int unsigned DELTA_W = 8;

    localparam logic [THRESH_W-1:0] LONG_PRESS_TIME_RESET = 16'd800;
    localparam logic                HIGH                  = 1'b1;

    localparam logic signed [DELTA_W-1:0] DELTA_MAX = 8'sh7F;
    localparam logic signed [DELTA_W-1:0] DELTA_MIN = 8'sh80;

    typedef struct packed {
        logic              chan_a;
        logic              chan_b;
        logic              touch_level;
        logic [TIME_W-1:0] now_ms;
        logic              take_events;
    } in_item_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] rotation_delta;
        logic                      short_press;
        logic                      long_press;
    } out_item_t;

    // per-item control from the top level to the tracker units
    typedef struct packed {
        logic fire;  // item in the input register is being processed this cycle
        logic take;  // item asks to read and clear the events
    } step_ctrl_t;

endpackage

`default_nettype wire

FILE: design/eapt_rotation.sv
// eapt_rotation: quadrature step accumulator with saturation and take/clear
// depends on eapt_pkg
`default_nettype none

module eapt_rotation
    import eapt_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire step_ctrl_t                ctrl,
    input  wire logic                      chan_a,
    input  wire logic                      chan_b,
    output logic signed [DELTA_W-1:0]      delta
);

    logic                      prev_a_reg, prev_a_next;
    logic signed [DELTA_W-1:0] sum_reg, sum_next;
    logic signed [DELTA_W-1:0] sum_upd;

    always_comb begin
        sum_upd = sum_reg;
        if (chan_a != prev_a_reg) begin
            if (chan_a != chan_b) begin
                if (sum_reg != DELTA_MAX) begin
                    sum_upd = sum_reg + 8'sd1;
                end
            end else begin
                if (sum_reg != DELTA_MIN) begin
                    sum_upd = sum_reg - 8'sd1;
                end
            end
        end
    end

    assign delta       = ctrl.take ? sum_upd : '0;
    assign sum_next    = ctrl.take ? '0 : sum_upd;
    assign prev_a_next = chan_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_a_reg <= HIGH;
            sum_reg    <= '0;
        end else if (ctrl.fire) begin
            prev_a_reg <= prev_a_next;
            sum_reg    <= sum_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/eapt_press.sv
// eapt_press: touch press tracker with short and long press flags
// depends on eapt_pkg
`default_nettype none

module eapt_press
    import eapt_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire step_ctrl_t          ctrl,
    input  wire logic                touch_level,
    input  wire logic [TIME_W-1:0]   now_ms,
    input  wire logic [THRESH_W-1:0] long_press_time,
    output logic                     short_press,
    output logic                     long_press
);

    logic              prev_touch_reg;
    logic [TIME_W-1:0] press_start_reg, press_start_next;
    logic              long_done_reg, long_done_next;
    logic              short_pend_reg, short_pend_next;
    logic              long_pend_reg, long_pend_next;

    logic              rising, falling, done_eff, long_fire, short_fire;
    logic [TIME_W-1:0] hold;

    always_comb begin
        rising           = touch_level && !prev_touch_reg;
        falling          = !touch_level && prev_touch_reg;
        press_start_next = rising ? now_ms : press_start_reg;
        done_eff         = rising ? 1'b0 : long_done_reg;
        // modular hold time, wrap-safe
        hold             = now_ms - press_start_next;
        long_fire        = touch_level && !done_eff
                           && (hold >= {{(TIME_W-THRESH_W){1'b0}}, long_press_time});
        short_fire       = falling && !done_eff;
        long_done_next   = done_eff || long_fire;

        short_press      = ctrl.take && (short_pend_reg || short_fire);
        long_press       = ctrl.take && (long_pend_reg || long_fire);
        short_pend_next  = !ctrl.take && (short_pend_reg || short_fire);
        long_pend_next   = !ctrl.take && (long_pend_reg || long_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_touch_reg  <= 1'b0;
            press_start_reg <= '0;
            long_done_reg   <= 1'b0;
            short_pend_reg  <= 1'b0;
            long_pend_reg   <= 1'b0;
        end else if (ctrl.fire) begin
            prev_touch_reg  <= touch_level;
            press_start_reg <= press_start_next;
            long_done_reg   <= long_done_next;
            short_pend_reg  <= short_pend_next;
            long_pend_reg   <= long_pend_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/encoder_and_press_tracker_unit.sv
// encoder_and_press_tracker_unit: top level, input and result registers around
// the rotation and press trackers; depends on eapt_pkg, eapt_rotation, eapt_press
`default_nettype none

// channel   direction  handshake              payload
// s_        in         s_valid / s_ready      s_data   (in_item_t)
// m_        out        m_valid / m_ready      m_data   (out_item_t)
// cfg_      in         cfg_valid / cfg_ready  cfg_data (long_press_time, 16 bits)
//
// one poll per clock sustained while m_ready stays high; a poll passes through the input
// register and then the result register before it is presented on m_
// the input register feeds the tracker logic, whose result lands in the result register
// the input register keeps taking polls while a result waits, until both are full
// synchronous active-low reset sets threshold to 800 ms, channel A history high
// cfg_ready is always high; the threshold is written on any cfg transfer

module encoder_and_press_tracker_unit
    import eapt_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire in_item_t            s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output out_item_t                m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [THRESH_W-1:0] cfg_data
);

    logic [THRESH_W-1:0] lpt_reg;
    logic                in_vld_reg;
    in_item_t            in_data_reg;
    logic                out_vld_reg;
    out_item_t           out_data_reg, out_data_next;
    logic                advance;
    step_ctrl_t          ctrl;

    // the held poll moves on when the result register is free or draining
    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    assign ctrl.fire = advance;
    assign ctrl.take = in_data_reg.take_events;

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lpt_reg <= LONG_PRESS_TIME_RESET;
        end else if (cfg_valid) begin
            lpt_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    eapt_rotation u_rotation (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .chan_a  (in_data_reg.chan_a),
        .chan_b  (in_data_reg.chan_b),
        .delta   (out_data_next.rotation_delta)
    );

    eapt_press u_press (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .touch_level     (in_data_reg.touch_level),
        .now_ms          (in_data_reg.now_ms),
        .long_press_time (lpt_reg),
        .short_press     (out_data_next.short_press),
        .long_press      (out_data_next.long_press)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire
